### sv/rotation_matrix_to_euler_assert.svh
// Assertion macros for the rotation matrix to Euler angle converter.
// Used by the top level only; needs no package.
`ifndef ROTATION_MATRIX_TO_EULER_ASSERT_SVH
`define ROTATION_MATRIX_TO_EULER_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define RME_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define RME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### sv/rme_pkg.sv
// Package for the rotation matrix to Euler angle converter.
// Holds widths, the CORDIC arctangent table and shared constants; depends on nothing.
package rme_pkg;
	localparam int CordicStagesDef = 16;
	localparam int TabLen = 24;
	localparam int InW = 16;
	localparam int AngW = 16;
	localparam int ThrW = 15;
	localparam int SqW = 32;
	localparam int RootW = 16;
	// CORDIC datapath width: operands scaled by 2^16 plus growth.
	localparam int CW = 36;
	localparam int ZW = 34;
	localparam logic signed [AngW-1:0] PiQ13 = 16'sd25736;
	localparam logic [30:0] PiQ29 = 31'd1686629713;

	typedef struct packed {
		logic signed [InW-1:0] r00;
		logic signed [InW-1:0] r10;
		logic signed [InW-1:0] r11;
		logic signed [InW-1:0] r12;
		logic signed [InW-1:0] r20;
		logic signed [InW-1:0] r21;
		logic signed [InW-1:0] r22;
	} mat_t;

	typedef struct packed {
		logic signed [AngW-1:0] angle_x;
		logic signed [AngW-1:0] angle_y;
		logic signed [AngW-1:0] angle_z;
		logic                   singular;
	} eul_t;

	// Arctangent of 2^-i in binary angle units (2^32 per turn).
	function automatic logic signed [ZW-1:0] atan_tab(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
			3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
			6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
			9: v = 32'h00145F2F;  10: v = 32'h000A2F98; 11: v = 32'h000517CC;
			12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2F9;
			15: v = 32'h0000517C; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
			18: v = 32'h00000A2F; 19: v = 32'h00000517; 20: v = 32'h0000028B;
			21: v = 32'h00000145; 22: v = 32'h000000A2; 23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return ZW'(signed'({1'b0, v}));
	endfunction
endpackage

### sv/rme_stream_if.sv
// Valid/ready stream interface carrying one payload of type T.
// Independent of the package.
interface rme_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/rme_cfg_if.sv
// Configuration write channel: valid, ready and the threshold value.
// Uses rme_pkg for the register width.
interface rme_cfg_if import rme_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [ThrW-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### sv/rotation_matrix_to_euler.sv
// Rotation matrix to x-y-z Euler angles. One matrix is accepted per cycle while
// the output is not stalled. The squares of r00 and r10 and their sum are
// registered, then the bit-per-stage square root gives sy, then the three
// parallel CORDIC arctangent pipelines produce the angles. The whole pipeline
// advances together and stalls when the output register is full and not taken.
// singular_threshold is written through cfg and is 1 after reset.
`include "rotation_matrix_to_euler_assert.svh"
module rotation_matrix_to_euler import rme_pkg::*; #(
	parameter int CORDIC_STAGES = CordicStagesDef
) (
	input  logic     clk,
	input  logic     arst_n,
	rme_stream_if.sink   in_ch,
	rme_stream_if.source out_ch,
	rme_cfg_if.sink      cfg
);
	localparam int NC = (CORDIC_STAGES > TabLen) ? TabLen : CORDIC_STAGES;
	localparam int CLat = NC + 4;

	logic            en;
	logic [ThrW-1:0] thr_q;
	mat_t            m_s1, m_s2;
	logic            v_s1, v_s2;
	logic [SqW-1:0]  a_s1, b_s1, sq_s2;
	logic            sq_vld;
	logic [RootW-1:0] sy;
	mat_t            m_r;
	logic            sing;
	logic            vld_c [CLat+1];
	logic            sing_c [CLat+1];
	logic signed [AngW-1:0] ax, ay, az;

	// Whole pipeline moves unless the output holds an untaken result.
	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ThrW'(1);
		end else if (cfg.valid) begin
			thr_q <= cfg.data;
		end
	end

	// Squares, then their sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= in_ch.data;
			a_s1 <= SqW'(in_ch.data.r00 * in_ch.data.r00);
			b_s1 <= SqW'(in_ch.data.r10 * in_ch.data.r10);
			m_s2 <= m_s1;
			sq_s2 <= a_s1 + b_s1;
		end
	end

	rme_isqrt #(.SideW($bits(mat_t))) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(v_s2), .in_sq(sq_s2),
		.in_side(m_s2), .out_valid(sq_vld), .out_root(sy), .out_side(m_r)
	);

	assign sing = {1'b0, sy} < {2'b0, thr_q};

	// Operand selection for the three arctangents.
	logic signed [InW:0] xy, xx, yy, yx, zy, zx;
	always_comb begin
		yy = -(InW+1)'(m_r.r20);
		yx = signed'({1'b0, sy});
		zy = (InW+1)'(m_r.r10);
		zx = (InW+1)'(m_r.r00);
		if (sing) begin
			xy = -(InW+1)'(m_r.r12);
			xx = (InW+1)'(m_r.r11);
		end else begin
			xy = (InW+1)'(m_r.r21);
			xx = (InW+1)'(m_r.r22);
		end
	end

	rme_atan2 #(.Stages(CORDIC_STAGES)) u_ax (.clk(clk), .en(en), .y_in(xy), .x_in(xx), .ang(ax));
	rme_atan2 #(.Stages(CORDIC_STAGES)) u_ay (.clk(clk), .en(en), .y_in(yy), .x_in(yx), .ang(ay));
	rme_atan2 #(.Stages(CORDIC_STAGES)) u_az (.clk(clk), .en(en), .y_in(zy), .x_in(zx), .ang(az));

	// Valid and branch flag travel beside the CORDIC pipelines.
	assign vld_c[0] = sq_vld;
	assign sing_c[0] = sing;
	for (genvar k = 0; k < CLat; k++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_c[k+1] <= 1'b0;
			end else if (en) begin
				vld_c[k+1] <= vld_c[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sing_c[k+1] <= sing_c[k];
			end
		end
	end

	assign out_ch.valid = vld_c[CLat];
	assign out_ch.data.angle_x = ax;
	assign out_ch.data.angle_y = ay;
	assign out_ch.data.angle_z = sing_c[CLat] ? '0 : az;
	assign out_ch.data.singular = sing_c[CLat];

	`RME_ASSERT_IMPL(a_in_ready, clk, arst_n, !out_ch.valid, in_ch.ready, "input stalled with empty output")
	`RME_ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data), "result changed while stalled")
	`RME_ASSERT_IMPL(a_range, clk, arst_n, out_ch.valid, out_ch.data.angle_y <= PiQ13 && out_ch.data.angle_y >= -PiQ13, "angle out of range")
endmodule

### sv/rme_isqrt.sv
// Pipelined integer square root, one result bit per stage, 16 stages.
// Uses rme_pkg; carries a sideband payload and valid alongside.
module rme_isqrt import rme_pkg::*; #(
	parameter int SideW = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [SqW-1:0]   in_sq,
	input  logic [SideW-1:0] in_side,
	output logic             out_valid,
	output logic [RootW-1:0] out_root,
	output logic [SideW-1:0] out_side
);
	localparam int N = RootW;
	logic [SqW+1:0]   rem_s [N+1];
	logic [RootW-1:0] root_s [N+1];
	logic [SqW-1:0]   sq_s [N+1];
	logic [SideW-1:0] side_s [N+1];
	logic             vld_s [N+1];

	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign sq_s[0] = in_sq;
	assign side_s[0] = in_side;
	assign vld_s[0] = in_valid;

	// Restoring square root: each stage brings down two radicand bits.
	for (genvar k = 0; k < N; k++) begin : g_st
		logic [SqW+1:0] rem_n, trial;
		always_comb begin
			rem_n = {rem_s[k][SqW-1:0], sq_s[k][SqW-1 -: 2]};
			trial = {{(SqW-RootW){1'b0}}, root_s[k], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_n >= trial) begin
					rem_s[k+1] <= rem_n - trial;
					root_s[k+1] <= {root_s[k][RootW-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= rem_n;
					root_s[k+1] <= {root_s[k][RootW-2:0], 1'b0};
				end
				sq_s[k+1] <= {sq_s[k][SqW-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign out_root = root_s[N];
	assign out_side = side_s[N];
endmodule

### sv/rme_atan2.sv
// Pipelined CORDIC arctangent: pre-rotation, one vectoring stage per
// register, then scaling to Q3.13 radians. Uses rme_pkg.
module rme_atan2 import rme_pkg::*; #(
	parameter int Stages = CordicStagesDef
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [InW:0]    y_in,
	input  logic signed [InW:0]    x_in,
	output logic signed [AngW-1:0] ang
);
	localparam int N = (Stages > TabLen) ? TabLen : Stages;
	logic signed [CW-1:0] x_s [N+1];
	logic signed [CW-1:0] y_s [N+1];
	logic signed [ZW-1:0] z_s [N+1];
	logic                 zero_s [N+1];
	logic [ZW-1:0]        mag_s1;
	logic                 neg_s1, zero_s1;
	logic [64:0]          prod_s2;
	logic                 neg_s2, zero_s2;

	// Pre-rotation into the right half plane; registered as stage 0.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (x_in == '0) && (y_in == '0);
			if (x_in < 0) begin
				if (y_in >= 0) begin
					x_s[0] <= CW'(y_in) <<< 16;
					y_s[0] <= -(CW'(x_in) <<< 16);
					z_s[0] <= ZW'(34'sh040000000);
				end else begin
					x_s[0] <= -(CW'(y_in) <<< 16);
					y_s[0] <= CW'(x_in) <<< 16;
					z_s[0] <= -ZW'(34'sh040000000);
				end
			end else begin
				x_s[0] <= CW'(x_in) <<< 16;
				y_s[0] <= CW'(y_in) <<< 16;
				z_s[0] <= '0;
			end
		end
	end

	// One vectoring micro-rotation per stage.
	for (genvar i = 0; i < N; i++) begin : g_cs
		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] >= 0) begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + atan_tab(i);
				end else begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - atan_tab(i);
				end
			end
		end
	end

	// Magnitude, multiply by pi, round and clamp over three stages.
	logic [AngW-1:0] q;
	always_comb begin
		q = (prod_s2[64:47] > 18'(PiQ13)) ? AngW'(PiQ13) : prod_s2[47+AngW-1:47];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= z_s[N] < 0;
			mag_s1 <= (z_s[N] < 0) ? ZW'(-z_s[N]) : ZW'(z_s[N]);
			zero_s1 <= zero_s[N];
			prod_s2 <= 65'(mag_s1) * 65'(PiQ29) + (65'd1 << 46);
			neg_s2 <= neg_s1;
			zero_s2 <= zero_s1;
			if (zero_s2) begin
				ang <= '0;
			end else begin
				ang <= neg_s2 ? -signed'(q) : signed'(q);
			end
		end
	end
endmodule
